// File: rtl/tpdl_pkg.sv
// Package for the tree path distance block: FSM states, opcodes, status codes
// and the saturating adder shared by the datapath. No dependencies.
`timescale 1ns / 1ps

package tpdl_pkg;

    localparam logic       OP_ADD         = 1'b0;
    localparam logic       OP_QUERY       = 1'b1;
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_MISSING = 1'b1;
    localparam logic [31:0] SUM_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ADD_LEVEL,
        ST_CLIMB,
        ST_CLIMB_WAIT,
        ST_LCA,
        ST_LCA_END,
        ST_FINISH
    } state_t;

    // min(a + b + c, 2^32-1)
    function automatic logic [31:0] sat_add3(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        logic [33:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        return (s[33:32] != 2'b00) ? SUM_MAX : s[31:0];
    endfunction

endpackage

// File: rtl/tpdl_lift_mem.sv
// Lifting table: ancestor and climb cost per (node, level), one write port,
// two registered read ports. Node 0 reads as the all-zero sentinel. Uses tpdl_pkg.
`timescale 1ns / 1ps

module tpdl_lift_mem #(
    parameter int NODE_W = 12,
    parameter int LVL_W  = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [NODE_W-1:0] wr_node,
    input  logic [LVL_W-1:0]  wr_lvl,
    input  logic [NODE_W-1:0] wr_anc,
    input  logic [31:0]       wr_cost,
    input  logic [NODE_W-1:0] rdx_node,
    input  logic [LVL_W-1:0]  rdx_lvl,
    input  logic [NODE_W-1:0] rdy_node,
    input  logic [LVL_W-1:0]  rdy_lvl,
    output logic [NODE_W-1:0] x_anc,
    output logic [31:0]       x_cost,
    output logic [NODE_W-1:0] y_anc,
    output logic [31:0]       y_cost
);
    import tpdl_pkg::*;

    localparam int ENTRY_W = NODE_W + 32;
    localparam int ADDR_W  = NODE_W + LVL_W;

    logic [ENTRY_W-1:0] lift_mem [2**ADDR_W];
    logic [ENTRY_W-1:0] x_data_reg;
    logic [ENTRY_W-1:0] y_data_reg;
    logic               x_zero_reg;
    logic               y_zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lift_mem[{wr_node, wr_lvl}] <= {wr_anc, wr_cost};
        end
        x_data_reg <= lift_mem[{rdx_node, rdx_lvl}];
        y_data_reg <= lift_mem[{rdy_node, rdy_lvl}];
        x_zero_reg <= (rdx_node == '0);
        y_zero_reg <= (rdy_node == '0);
    end

    assign x_anc  = x_zero_reg ? '0 : x_data_reg[ENTRY_W-1:32];
    assign x_cost = x_zero_reg ? '0 : x_data_reg[31:0];
    assign y_anc  = y_zero_reg ? '0 : y_data_reg[ENTRY_W-1:32];
    assign y_cost = y_zero_reg ? '0 : y_data_reg[31:0];

endmodule

// File: rtl/tree_path_distance_lifting.sv
// Tree path distance top level: depth store, add/query sequencer, output register.
// Depends on tpdl_pkg and tpdl_lift_mem.
//
//   channel | signals                                        | dir | transfer
//   in      | opcode first_node second_node edge_weight      | in  | in_valid & in_ready
//   out     | path_weight status                             | out | out_valid & out_ready
//
// After reset the depth store is cleared, one entry per cycle, with in_ready low.
// An add writes one table row per level through the single table write port.
// A query climbs the deeper node by the depth gap, one bit of the gap per step, then
// makes ancestor passes that read one row pair per level; a query with an unknown
// node skips both and goes straight to the output register.
// A result waits in the output register; a new item is accepted meanwhile, and a query
// that finishes while the register is still full holds until out_ready.
`timescale 1ns / 1ps

module tree_path_distance_lifting #(
    parameter int MAX_NODES   = 4096,
    parameter int LIFT_LEVELS = 12,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [11:0] first_node,
    input  logic [11:0] second_node,
    input  logic [15:0] edge_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] path_weight,
    output logic        status
);
    import tpdl_pkg::*;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int DEPTH_W   = NODE_W;
    localparam int LVL_W     = $clog2(LIFT_LEVELS);
    localparam int KEEP_BITS = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam logic [LVL_W-1:0]  TOP_LVL  = LVL_W'(LIFT_LEVELS - 1);
    localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(MAX_NODES - 1);

    state_t state_reg, state_next;

    logic [NODE_W-1:0]    clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          path_weight_reg;
    logic                 status_reg;

    logic                 op_reg, op_next;
    logic [NODE_W-1:0]    a_reg, a_next;
    logic [NODE_W-1:0]    b_reg, b_next;
    logic [KEEP_BITS-1:0] w_reg, w_next;
    logic                 a_ok_reg, a_ok_next;
    logic                 b_rng_reg, b_rng_next;
    logic [NODE_W-1:0]    x_reg, x_next;
    logic [NODE_W-1:0]    y_reg, y_next;
    logic [DEPTH_W-1:0]   diff_reg, diff_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [31:0]          sum_reg, sum_next;
    logic [31:0]          prev_cost_reg, prev_cost_next;
    logic                 miss_reg, miss_next;

    logic [DEPTH_W-1:0]   depth_mem [MAX_NODES];
    logic [DEPTH_W-1:0]   dep_a_reg;
    logic [DEPTH_W-1:0]   dep_b_reg;
    logic                 dep_we;
    logic [NODE_W-1:0]    dep_waddr;
    logic [DEPTH_W-1:0]   dep_wdata;
    logic [NODE_W-1:0]    dep_ra;
    logic [NODE_W-1:0]    dep_rb;

    logic                 tbl_we;
    logic [NODE_W-1:0]    wr_node;
    logic [LVL_W-1:0]     wr_lvl;
    logic [NODE_W-1:0]    wr_anc;
    logic [31:0]          wr_cost;
    logic [NODE_W-1:0]    rdx_node;
    logic [LVL_W-1:0]     rdx_lvl;
    logic [NODE_W-1:0]    rdy_node;
    logic [LVL_W-1:0]     rdy_lvl;
    logic [NODE_W-1:0]    x_anc;
    logic [31:0]          x_cost;
    logic [NODE_W-1:0]    y_anc;
    logic [31:0]          y_cost;

    logic                 in_xfer;
    logic                 out_load;
    logic                 add_ok;
    logic                 query_ok;
    logic                 a_deeper;
    logic                 differ;
    logic [NODE_W-1:0]    x_step;
    logic [NODE_W-1:0]    y_step;
    logic [LVL_W-1:0]     lvl_down;
    logic [31:0]          root_cost;

    tpdl_lift_mem #(
        .NODE_W (NODE_W),
        .LVL_W  (LVL_W)
    ) u_lift_mem (
        .clk      (clk),
        .wr_en    (tbl_we),
        .wr_node  (wr_node),
        .wr_lvl   (wr_lvl),
        .wr_anc   (wr_anc),
        .wr_cost  (wr_cost),
        .rdx_node (rdx_node),
        .rdx_lvl  (rdx_lvl),
        .rdy_node (rdy_node),
        .rdy_lvl  (rdy_lvl),
        .x_anc    (x_anc),
        .x_cost   (x_cost),
        .y_anc    (y_anc),
        .y_cost   (y_cost)
    );

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[dep_waddr] <= dep_wdata;
        end
        dep_a_reg <= depth_mem[dep_ra];
        dep_b_reg <= depth_mem[dep_rb];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign path_weight = path_weight_reg;
    assign status    = status_reg;

    assign add_ok   = a_ok_reg && (dep_a_reg == '0) && b_rng_reg
                      && ((b_reg == '0) || (dep_b_reg != '0));
    assign query_ok = a_ok_reg && b_rng_reg && (b_reg != '0)
                      && (dep_a_reg != '0) && (dep_b_reg != '0);
    assign a_deeper = dep_a_reg > dep_b_reg;
    assign differ   = x_anc != y_anc;
    assign x_step   = differ ? x_anc : x_reg;
    assign y_step   = differ ? y_anc : y_reg;
    assign lvl_down = (lvl_reg == '0) ? '0 : lvl_reg - 1'b1;
    assign root_cost = (b_reg == '0) ? '0 : 32'(w_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (op_reg == OP_ADD)
                begin
                    state_next = add_ok ? ST_ADD_LEVEL : ST_IDLE;
                end
                else
                begin
                    state_next = query_ok ? ST_CLIMB : ST_FINISH;
                end
            end
            ST_ADD_LEVEL:
            begin
                if (lvl_reg == TOP_LVL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLIMB:
            begin
                if (diff_reg == '0)
                begin
                    state_next = (x_reg == y_reg) ? ST_FINISH : ST_LCA;
                end
                else if ((lvl_reg == TOP_LVL) || diff_reg[0])
                begin
                    state_next = ST_CLIMB_WAIT;
                end
            end
            ST_CLIMB_WAIT:
            begin
                state_next = ST_CLIMB;
            end
            ST_LCA:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_LCA_END;
                end
            end
            ST_LCA_END:
            begin
                state_next = differ ? ST_LCA : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory ports
    always_comb
    begin
        dep_we    = 1'b0;
        dep_waddr = a_reg;
        dep_wdata = dep_b_reg + 1'b1;
        dep_ra    = NODE_W'(first_node);
        dep_rb    = NODE_W'(second_node);
        tbl_we    = 1'b0;
        wr_node   = a_reg;
        wr_lvl    = lvl_reg;
        wr_anc    = x_anc;
        wr_cost   = sat_add3(x_cost, prev_cost_reg, '0);
        rdx_node  = x_reg;
        rdx_lvl   = lvl_reg;
        rdy_node  = y_reg;
        rdy_lvl   = lvl_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                dep_we    = 1'b1;
                dep_waddr = clr_reg;
                dep_wdata = '0;
            end
            ST_CHECK:
            begin
                if ((op_reg == OP_ADD) && add_ok)
                begin
                    dep_we   = 1'b1;
                    tbl_we   = 1'b1;
                    wr_lvl   = '0;
                    wr_anc   = b_reg;
                    wr_cost  = root_cost;
                    rdx_node = b_reg;
                    rdx_lvl  = '0;
                end
            end
            ST_ADD_LEVEL:
            begin
                tbl_we   = 1'b1;
                rdx_node = x_anc;
            end
            ST_CLIMB:
            begin
                if (diff_reg == '0)
                begin
                    rdx_lvl = TOP_LVL;
                    rdy_lvl = TOP_LVL;
                end
            end
            ST_LCA:
            begin
                rdx_node = x_step;
                rdy_node = y_step;
                rdx_lvl  = lvl_down;
                rdy_lvl  = lvl_down;
            end
            ST_LCA_END:
            begin
                rdx_lvl = TOP_LVL;
                rdy_lvl = TOP_LVL;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        clr_next       = clr_reg;
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        a_ok_next      = a_ok_reg;
        b_rng_next     = b_rng_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        diff_next      = diff_reg;
        lvl_next       = lvl_reg;
        sum_next       = sum_reg;
        prev_cost_next = prev_cost_reg;
        miss_next      = miss_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = opcode;
                    a_next     = NODE_W'(first_node);
                    b_next     = NODE_W'(second_node);
                    w_next     = edge_weight[KEEP_BITS-1:0];
                    a_ok_next  = (first_node != '0) && (32'(first_node) < MAX_NODES);
                    b_rng_next = 32'(second_node) < MAX_NODES;
                end
            end
            ST_CHECK:
            begin
                lvl_next       = (op_reg == OP_ADD) ? LVL_W'(1) : '0;
                prev_cost_next = root_cost;
                sum_next       = '0;
                miss_next      = !query_ok;
                x_next         = a_deeper ? b_reg : a_reg;
                y_next         = a_deeper ? a_reg : b_reg;
                diff_next      = a_deeper ? dep_a_reg - dep_b_reg : dep_b_reg - dep_a_reg;
            end
            ST_ADD_LEVEL:
            begin
                prev_cost_next = wr_cost;
                lvl_next       = (lvl_reg == TOP_LVL) ? lvl_reg : lvl_reg + 1'b1;
            end
            ST_CLIMB:
            begin
                if (diff_reg == '0)
                begin
                    lvl_next = TOP_LVL;
                end
                else if ((lvl_reg != TOP_LVL) && !diff_reg[0])
                begin
                    diff_next = diff_reg >> 1;
                    lvl_next  = lvl_reg + 1'b1;
                end
            end
            ST_CLIMB_WAIT:
            begin
                sum_next = sat_add3(sum_reg, y_cost, '0);
                y_next   = y_anc;
                if (lvl_reg == TOP_LVL)
                begin
                    diff_next = diff_reg - 1'b1;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    lvl_next  = lvl_reg + 1'b1;
                end
            end
            ST_LCA:
            begin
                x_next   = x_step;
                y_next   = y_step;
                sum_next = differ ? sat_add3(sum_reg, x_cost, y_cost) : sum_reg;
                lvl_next = lvl_down;
            end
            ST_LCA_END:
            begin
                if (differ)
                begin
                    lvl_next = TOP_LVL;
                end
                else
                begin
                    sum_next = sat_add3(sum_reg, x_cost, y_cost);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        a_ok_reg      <= a_ok_next;
        b_rng_reg     <= b_rng_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        diff_reg      <= diff_next;
        lvl_reg       <= lvl_next;
        sum_reg       <= sum_next;
        prev_cost_reg <= prev_cost_next;
        miss_reg      <= miss_next;
        if (out_load)
        begin
            path_weight_reg <= miss_reg ? '0 : sum_reg;
            status_reg      <= miss_reg ? STATUS_MISSING : STATUS_OK;
        end
    end

endmodule
